@@ sv/aavr_pkg.sv @@
package aavr_pkg;

  localparam int FRAC_BITS_DEF    = 14;
  localparam int CORDIC_STEPS_DEF = 16;

  // The CORDIC runs on a Q2.30 datapath with two guard bits.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } out_item_t;

  // atan(2^-i), with 2^31 standing for pi.
  function automatic logic signed [CW-1:0] atan_val(input logic [5:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      6'd0:  r = 34'sd536870912;
      6'd1:  r = 34'sd316933406;
      6'd2:  r = 34'sd167458907;
      6'd3:  r = 34'sd85004756;
      6'd4:  r = 34'sd42667331;
      6'd5:  r = 34'sd21354465;
      6'd6:  r = 34'sd10679838;
      6'd7:  r = 34'sd5340245;
      6'd8:  r = 34'sd2670163;
      6'd9:  r = 34'sd1335087;
      6'd10: r = 34'sd667544;
      6'd11: r = 34'sd333772;
      6'd12: r = 34'sd166886;
      6'd13: r = 34'sd83443;
      6'd14: r = 34'sd41722;
      6'd15: r = 34'sd20861;
      6'd16: r = 34'sd10430;
      6'd17: r = 34'sd5215;
      6'd18: r = 34'sd2608;
      6'd19: r = 34'sd1304;
      6'd20: r = 34'sd652;
      6'd21: r = 34'sd326;
      6'd22: r = 34'sd163;
      6'd23: r = 34'sd81;
      6'd24: r = 34'sd41;
      6'd25: r = 34'sd20;
      6'd26: r = 34'sd10;
      6'd27: r = 34'sd5;
      6'd28: r = 34'sd3;
      6'd29: r = 34'sd1;
      6'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/axis_angle_vector_rotation_core.sv @@
// Rotates a 3D vector about an axis by an angle, fully pipelined: one
// transaction may be started in every cycle, busy is held low, and each
// result passes through the CORDIC stage chain and then six arithmetic
// stages (axis products, rounding, matrix terms, element rounding, dot
// products, final rounding and saturation). The rotation uses the
// transpose of the usual Rodrigues matrix, so the vector turns in the
// clockwise sense about the axis. Results are shown for one cycle under
// out_valid and cannot be held off, so the receiver must take every one.
module axis_angle_vector_rotation_core #(
  parameter int FRAC_BITS    = aavr_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  aavr_pkg::in_item_t in_item,
  output logic               out_valid,
  output aavr_pkg::out_item_t out_item
);

  localparam int CW  = aavr_pkg::CW;
  localparam int SH  = 30 - FRAC_BITS;
  // Wide datapath width: covers products of Q2.2F elements and vectors.
  localparam int PW  = 2 * FRAC_BITS + 24;
  // Cosine, sine and one minus cosine reach 2^(F+1) in magnitude.
  localparam int KW  = FRAC_BITS + 3;
  // Rounded axis pair products reach 2^(30-F) in magnitude.
  localparam int QW  = 33 - FRAC_BITS;
  // Rounded matrix elements.
  localparam int MW  = (FRAC_BITS < 16) ? 35 - FRAC_BITS : 19;
  localparam int NST = CORDIC_STEPS + 1;

  typedef struct packed {
    logic signed [15:0] vx, vy, vz, ax, ay, az;
  } geo_t;

  typedef struct packed {
    logic signed [CW-1:0] x, y, z;
    logic                 flip;
  } cst_t;

  // The pipeline never stalls.
  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start & ~busy;

  // ---------------- CORDIC stage chain ----------------
  logic [NST-1:0] cv_r;
  cst_t           cs_r  [NST];
  geo_t           geo_r [NST];

  cst_t cs_init;
  always_comb begin
    logic signed [CW-1:0] za;
    za = CW'(in_item.turn_angle) <<< 16;
    cs_init.flip = 1'b0;
    if (in_item.turn_angle > 16'sd16384) begin
      za = za - (CW'(1) <<< 31);
      cs_init.flip = 1'b1;
    end else if (in_item.turn_angle < -16'sd16384) begin
      za = za + (CW'(1) <<< 31);
      cs_init.flip = 1'b1;
    end
    cs_init.x = aavr_pkg::CORDIC_INV_GAIN;
    cs_init.y = '0;
    cs_init.z = za;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else        cv_r[0] <= in_fire;
    cs_r[0]  <= cs_init;
    geo_r[0] <= '{in_item.vec_x, in_item.vec_y, in_item.vec_z,
                  in_item.axis_x, in_item.axis_y, in_item.axis_z};
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cst_t nxt;
    always_comb begin
      logic signed [CW-1:0] xs, ys, at;
      xs = (i < 32) ? (cs_r[i].x >>> i) : (cs_r[i].x >>> 31);
      ys = (i < 32) ? (cs_r[i].y >>> i) : (cs_r[i].y >>> 31);
      at = (i < 32) ? aavr_pkg::atan_val(6'(i)) : '0;
      nxt.flip = cs_r[i].flip;
      if (i >= 32) begin
        nxt = cs_r[i];
      end else if (!cs_r[i].z[CW-1]) begin
        nxt.x = cs_r[i].x - ys;
        nxt.y = cs_r[i].y + xs;
        nxt.z = cs_r[i].z - at;
      end else begin
        nxt.x = cs_r[i].x + ys;
        nxt.y = cs_r[i].y - xs;
        nxt.z = cs_r[i].z + at;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else        cv_r[i+1] <= cv_r[i];
      cs_r[i+1]  <= nxt;
      geo_r[i+1] <= geo_r[i];
    end
  end

  // Round half up by n bits (n may be zero) on the wide datapath.
  function automatic logic signed [PW-1:0] rnd_w(input logic signed [PW-1:0] v,
                                                 input int n);
    logic signed [PW-1:0] r;
    if (n == 0) r = v;
    else r = (v + (PW'(1) <<< (n - 1))) >>> n;
    return r;
  endfunction

  function automatic logic signed [KW-1:0] clamp_one(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] one;
    one = PW'(1) <<< FRAC_BITS;
    if (v > one)       return KW'(one);
    else if (v < -one) return KW'(-one);
    else               return KW'(v);
  endfunction

  // ---------------- Stage A: sin/cos, axis products ----------------
  logic                 a_v_r;
  logic signed [KW-1:0] c_r, s_r;
  logic signed [PW-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  geo_t                 ga_r;

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] xf, yf;
    geo_t g;
    g  = geo_r[NST-1];
    xf = cs_r[NST-1].flip ? -cs_r[NST-1].x : cs_r[NST-1].x;
    yf = cs_r[NST-1].flip ? -cs_r[NST-1].y : cs_r[NST-1].y;
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= cv_r[NST-1];
    c_r   <= clamp_one(rnd_w(PW'(xf), SH));
    s_r   <= clamp_one(rnd_w(PW'(yf), SH));
    pxx_r <= PW'(g.ax) * PW'(g.ax);
    pyy_r <= PW'(g.ay) * PW'(g.ay);
    pzz_r <= PW'(g.az) * PW'(g.az);
    pxy_r <= PW'(g.ax) * PW'(g.ay);
    pxz_r <= PW'(g.ax) * PW'(g.az);
    pyz_r <= PW'(g.ay) * PW'(g.az);
    ga_r  <= g;
  end

  // ---------------- Stage B: round products, form 1-c ----------------
  logic                 b_v_r;
  logic signed [KW-1:0] cb_r, sb_r, omc_r;
  logic signed [QW-1:0] qxx_r, qyy_r, qzz_r, qxy_r, qxz_r, qyz_r;
  geo_t                 gb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else        b_v_r <= a_v_r;
    cb_r  <= c_r;
    sb_r  <= s_r;
    omc_r <= (KW'(1) <<< FRAC_BITS) - c_r;
    qxx_r <= QW'(rnd_w(pxx_r, FRAC_BITS));
    qyy_r <= QW'(rnd_w(pyy_r, FRAC_BITS));
    qzz_r <= QW'(rnd_w(pzz_r, FRAC_BITS));
    qxy_r <= QW'(rnd_w(pxy_r, FRAC_BITS));
    qxz_r <= QW'(rnd_w(pxz_r, FRAC_BITS));
    qyz_r <= QW'(rnd_w(pyz_r, FRAC_BITS));
    gb_r  <= gb_in();
  end

  function automatic geo_t gb_in();
    return ga_r;
  endfunction

  // ---------------- Stage C: matrix terms ----------------
  logic                 c_v_r;
  logic signed [PW-1:0] t_r [9];
  geo_t                 gc_r;

  always_ff @(posedge clk) begin
    logic signed [PW-1:0] one_w, azs, ays, axs;
    one_w = PW'(1) <<< FRAC_BITS;
    azs = PW'(gb_r.az) * PW'(sb_r);
    ays = PW'(gb_r.ay) * PW'(sb_r);
    axs = PW'(gb_r.ax) * PW'(sb_r);
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= b_v_r;
    t_r[0] <= PW'(qxx_r) * one_w + (PW'(qyy_r) + PW'(qzz_r)) * PW'(cb_r);
    t_r[1] <= PW'(qxy_r) * PW'(omc_r) + azs;
    t_r[2] <= PW'(qxz_r) * PW'(omc_r) - ays;
    t_r[3] <= PW'(qxy_r) * PW'(omc_r) - azs;
    t_r[4] <= PW'(qyy_r) * one_w + (PW'(qxx_r) + PW'(qzz_r)) * PW'(cb_r);
    t_r[5] <= PW'(qyz_r) * PW'(omc_r) + axs;
    t_r[6] <= PW'(qxz_r) * PW'(omc_r) + ays;
    t_r[7] <= PW'(qyz_r) * PW'(omc_r) - axs;
    t_r[8] <= PW'(qzz_r) * one_w + (PW'(qxx_r) + PW'(qyy_r)) * PW'(cb_r);
    gc_r   <= gb_r;
  end

  // ---------------- Stage D: round matrix elements ----------------
  logic                 d_v_r;
  logic signed [MW-1:0] m_r [9];
  geo_t                 gd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else        d_v_r <= c_v_r;
    for (int k = 0; k < 9; k++) m_r[k] <= MW'(rnd_w(t_r[k], FRAC_BITS));
    gd_r <= gc_r;
  end

  // ---------------- Stage E: dot products ----------------
  logic                 e_v_r;
  logic signed [PW-1:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else        e_v_r <= d_v_r;
    for (int k = 0; k < 3; k++) begin
      acc_r[k] <= PW'(m_r[3*k])   * PW'(gd_r.vx)
                + PW'(m_r[3*k+1]) * PW'(gd_r.vy)
                + PW'(m_r[3*k+2]) * PW'(gd_r.vz);
    end
  end

  // ---------------- Stage F: round, saturate, deliver ----------------
  localparam int ONE_LIM = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int NEG_LIM = (FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS);

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = rnd_w(v, FRAC_BITS);
    if (r > PW'(ONE_LIM))       return 16'(ONE_LIM);
    else if (r < -PW'(NEG_LIM)) return 16'(-NEG_LIM);
    else                        return 16'(r);
  endfunction

  logic                out_valid_r;
  aavr_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= e_v_r;
    out_item_r <= '{sat16(acc_r[0]), sat16(acc_r[1]), sat16(acc_r[2])};
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
